// ===== hw/rtl/text_console_cell_writer_assert.svh =====
// Assertion macros shared by the text console cell writer RTL.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tccw: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tccw: next-cycle check failed");

`endif

// ===== hw/rtl/tccw_pkg.sv =====
// Package with the types, constants and codes of the text console cell writer.
package tccw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Internal widths derived from the geometry.
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int LIN_W  = $clog2(CELL_COUNT + 1);

    // Port field widths.
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int BACK_W     = 3;
    localparam int FORE_W     = 4;
    localparam int CELL_ROW_W = 5;
    localparam int CELL_COL_W = 7;
    localparam int CURSOR_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Special character codes.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACK_COLOR = 2'd0,
        CFG_FORE_COLOR = 2'd1,
        CFG_BLINK      = 2'd2
    } cfg_idx_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // One screen cell as stored.
    typedef struct packed {
        logic              blink;
        logic [BACK_W-1:0] back;
        logic [FORE_W-1:0] fore;
        logic [CHAR_W-1:0] ch;
    } cell_t;

    // Input word.
    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [CHAR_W-1:0]     char_code;
        logic                  last_char;
        logic [CELL_ROW_W-1:0] cell_row;
        logic [CELL_COL_W-1:0] cell_col;
    } in_t;

    // Result word.
    typedef struct packed {
        logic [CHAR_W-1:0]   cell_char;
        logic [BACK_W-1:0]   cell_back;
        logic [FORE_W-1:0]   cell_fore;
        logic                cell_blink;
        logic [CURSOR_W-1:0] cursor_pos;
        logic [CURSOR_W-1:0] shown_cursor;
        logic                scrolled;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec_put;
        logic sweep_all_init;
        logic sweep_row_init;
        logic sweep_step;
        logic load_result;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             scroll;
        logic             sweep_last;
    } status_t;

endpackage

// ===== hw/rtl/tccw_datapath.sv =====
// Datapath of the text console cell writer: screen store, cursor, sweeps and result word.
module tccw_datapath
    import tccw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_t                 ctrl,
    output status_t               status,
    input  in_t                   s_data,
    output out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Logical row plus the ring offset, folded back into the store.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] log_row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, log_row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // First store address of a physical row.
    function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] prow);
        return ADDR_W'(prow) * ADDR_W'(COLUMNS);
    endfunction

    in_t               item_reg;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [LIN_W-1:0]  cur_lin_reg, cur_lin_next;
    logic [LIN_W-1:0]  vis_reg;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic              scrolled_reg;
    logic [BACK_W-1:0] back_color_reg;
    logic [FORE_W-1:0] fore_color_reg;
    logic              blink_reg;
    logic [ADDR_W-1:0] sweep_ptr_reg;
    logic [ADDR_W-1:0] sweep_end_reg;
    cell_t             rdata_reg;
    out_t              out_reg;

    cell_t             mem [CELL_COUNT];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    cell_t             mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;

    logic              is_nul;
    logic              is_nl;
    logic              is_char;
    logic              row_adv;
    logic              scroll;
    logic [LIN_W-1:0]  lin_step;
    logic [LIN_W-1:0]  lin_adv;
    logic [ADDR_W-1:0] put_addr;
    cell_t             res_cell;

    // Read address of the addressed cell, zero when it lies off the screen.
    always_comb begin
        rd_in_range = (32'(item_reg.cell_row) < ROWS) && (32'(item_reg.cell_col) < COLUMNS);
        rd_addr     = '0;
        if (rd_in_range) begin
            rd_addr = row_base(phys_row(ROW_W'(item_reg.cell_row), top_reg))
                    + ADDR_W'(item_reg.cell_col);
        end
    end

    // Cursor advance for a put.
    always_comb begin
        is_nul   = (item_reg.char_code == NUL_CODE);
        is_nl    = (item_reg.char_code == NEWLINE_CODE);
        is_char  = !is_nul && !is_nl;
        row_adv  = is_nl || (is_char && (cur_col_reg == COL_W'(COLUMNS - 1)));
        scroll   = row_adv && (cur_row_reg == ROW_W'(ROWS - 1));
        lin_step = is_nl ? (LIN_W'(COLUMNS) - LIN_W'(cur_col_reg)) : LIN_W'(1);
        lin_adv  = cur_lin_reg + lin_step;
        put_addr = row_base(phys_row(cur_row_reg, top_reg)) + ADDR_W'(cur_col_reg);

        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        cur_lin_next = cur_lin_reg;
        top_next     = top_reg;
        if (!is_nul) begin
            cur_col_next = row_adv ? '0 : cur_col_reg + COL_W'(1);
            if (scroll) begin
                cur_lin_next = lin_adv - LIN_W'(COLUMNS);
                top_next     = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + ROW_W'(1);
            end else begin
                cur_lin_next = lin_adv;
                if (row_adv) begin
                    cur_row_next = cur_row_reg + ROW_W'(1);
                end
            end
        end
    end

    // Store write port: a written character or a zero from a sweep.
    always_comb begin
        mem_we    = ctrl.sweep_step || (ctrl.exec_put && is_char);
        mem_waddr = ctrl.sweep_step ? sweep_ptr_reg : put_addr;
        mem_wdata = '0;
        if (!ctrl.sweep_step) begin
            mem_wdata.blink = blink_reg;
            mem_wdata.back  = back_color_reg;
            mem_wdata.fore  = fore_color_reg;
            mem_wdata.ch    = item_reg.char_code;
        end
    end

    // Screen store with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Item register.
    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            item_reg <= s_data;
        end
    end

    // Cursor, ring offset and scroll flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            cur_lin_reg  <= '0;
            vis_reg      <= '0;
            top_reg      <= '0;
            scrolled_reg <= 1'b0;
        end else begin
            if (ctrl.load_item) begin
                scrolled_reg <= 1'b0;
            end
            if (ctrl.exec_put) begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
                cur_lin_reg <= cur_lin_next;
                top_reg     <= top_next;
                if (scroll) begin
                    scrolled_reg <= 1'b1;
                end
                if (item_reg.last_char) begin
                    vis_reg <= cur_lin_next;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            back_color_reg <= '0;
            fore_color_reg <= FORE_W'(15);
            blink_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BACK_COLOR: back_color_reg <= cfg_wdata[BACK_W-1:0];
                CFG_FORE_COLOR: fore_color_reg <= cfg_wdata[FORE_W-1:0];
                CFG_BLINK:      blink_reg      <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // Sweep pointer; after reset it covers the whole store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_ptr_reg <= '0;
            sweep_end_reg <= ADDR_W'(CELL_COUNT - 1);
        end else if (ctrl.sweep_all_init) begin
            sweep_ptr_reg <= '0;
            sweep_end_reg <= ADDR_W'(CELL_COUNT - 1);
        end else if (ctrl.sweep_row_init) begin
            // The old top row becomes the new bottom row.
            sweep_ptr_reg <= row_base(top_reg);
            sweep_end_reg <= row_base(top_reg) + ADDR_W'(COLUMNS - 1);
        end else if (ctrl.sweep_step) begin
            sweep_ptr_reg <= sweep_ptr_reg + ADDR_W'(1);
        end
    end

    // Result word.
    always_comb begin
        res_cell = '0;
        if ((item_reg.command == CMD_READ) && rd_in_range) begin
            res_cell = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_result) begin
            out_reg.cell_char    <= res_cell.ch;
            out_reg.cell_back    <= res_cell.back;
            out_reg.cell_fore    <= res_cell.fore;
            out_reg.cell_blink   <= res_cell.blink;
            out_reg.cursor_pos   <= CURSOR_W'(cur_lin_reg);
            out_reg.shown_cursor <= CURSOR_W'(vis_reg);
            out_reg.scrolled     <= scrolled_reg;
        end
    end

    assign m_data            = out_reg;
    assign status.cmd        = item_reg.command;
    assign status.scroll     = scroll;
    assign status.sweep_last = (sweep_ptr_reg == sweep_end_reg);

endmodule

// ===== hw/rtl/tccw_ctrl.sv =====
// Controller state machine of the text console cell writer.
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output ctrl_t   ctrl,
    input  status_t status
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        out_free   = !m_valid_reg || m_ready;
        case (state_reg)
            ST_INIT: begin
                ctrl.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load_item = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.cmd)
                    CMD_PUT: begin
                        ctrl.exec_put = 1'b1;
                        if (status.scroll) begin
                            ctrl.sweep_row_init = 1'b1;
                            state_next          = ST_SWEEP;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    CMD_CLEAR: begin
                        ctrl.sweep_all_init = 1'b1;
                        state_next          = ST_SWEEP;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SWEEP: begin
                ctrl.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register and take the next word.
                if (out_free) begin
                    ctrl.load_result = 1'b1;
                    s_ready          = 1'b1;
                    if (s_valid) begin
                        ctrl.load_item = 1'b1;
                        state_next     = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the word is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/text_console_cell_writer.sv =====
// Top level of the text console cell writer.
//
// Usage: input words arrive on s_valid/s_ready/s_data (command, character, last-char
// flag, read row and column); one result word per input word leaves on
// m_valid/m_ready/m_data. Colors and blink are set through cfg_wr_en, cfg_index and
// cfg_wdata, written in one cycle while the block is idle.
// Sequence: a put, a read or an unused command passes the execute state, then the
// done state loads the output register. A put that scrolls first clears the
// recycled bottom row one cell per cycle on the store's single write port; the
// rows themselves are not moved, a ring offset selects the top row. A clear first
// clears the whole store, one cell per cycle. While the done state loads a result
// into a free output register, it already accepts the next input word.
// Reset: a synchronous active-low reset starts a clearing pass over the whole screen
// store; s_ready stays low until it is done. Configuration writes are taken during
// that pass.
// Stalls: the output register holds a finished word while m_ready is low; the block
// still accepts and executes one more input word, then waits with s_ready low.
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctrl_t   ctrl;
    status_t status;

    // Sequencer.
    tccw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl),
        .status  (status)
    );

    // Screen store and cursor.
    tccw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .status    (status),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    `include "text_console_cell_writer_assert.svh"

    // The reported cursor always lies on the screen.
    `TCCW_ASSERT_IMPLY(a_cursor_on_screen, m_valid, m_data.cursor_pos < CURSOR_W'(CELL_COUNT))
    // After a scroll the cursor sits on the bottom row.
    `TCCW_ASSERT_IMPLY(a_scroll_bottom_row, m_valid && m_data.scrolled, m_data.cursor_pos >= CURSOR_W'((ROWS - 1) * COLUMNS))
    // An accepted word leaves s_ready low while it executes.
    `TCCW_ASSERT_NEXT(a_accept_then_busy, s_valid && s_ready, !s_ready)
    // A sweep never shares the write port with a character write.
    `TCCW_ASSERT_IMPLY(a_sweep_exclusive, ctrl.sweep_step, !ctrl.exec_put && !ctrl.load_item)

endmodule

// ===== tb/text_console_cell_writer_check.sv =====
// Checker for the text console cell writer: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps

module text_console_cell_writer_check
    import tccw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    // Shadow copy of the screen, the cursors and the attribute registers.
    cell_t             screen [CELL_COUNT];
    int unsigned       cursor_lin;
    int unsigned       shown_lin;
    logic [BACK_W-1:0] back_reg;
    logic [FORE_W-1:0] fore_reg;
    logic              blink_reg;

    // Result words predicted for accepted input words, oldest first.
    out_t console_replies [$];
    int   words_seen;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t: result word %0d: %s", $time, words_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Applies one input word to the shadow state and returns the result word it causes.
    function automatic out_t console_step(input in_t w);
        out_t  r;
        cell_t rd;
        logic  moved;
        r     = '0;
        rd    = '0;
        moved = 1'b0;
        case (w.command)
            CMD_PUT: begin
                if (w.char_code != NUL_CODE) begin
                    if (w.char_code == NEWLINE_CODE) begin
                        cursor_lin = (cursor_lin / COLUMNS + 1) * COLUMNS;
                    end else begin
                        if (cursor_lin < CELL_COUNT) begin
                            screen[cursor_lin].blink = blink_reg;
                            screen[cursor_lin].back  = back_reg;
                            screen[cursor_lin].fore  = fore_reg;
                            screen[cursor_lin].ch    = w.char_code;
                        end
                        cursor_lin++;
                    end
                    // Past the last cell: every row moves up and the bottom row is blanked.
                    if (cursor_lin >= CELL_COUNT) begin
                        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                            screen[i] = screen[i + COLUMNS];
                        end
                        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                            screen[i] = '0;
                        end
                        cursor_lin -= COLUMNS;
                        moved = 1'b1;
                    end
                end
                // The shown cursor follows even when a NUL character wrote nothing.
                if (w.last_char) begin
                    shown_lin = cursor_lin;
                end
            end
            CMD_READ: begin
                if (w.cell_row < ROWS && w.cell_col < COLUMNS) begin
                    rd = screen[w.cell_row * COLUMNS + w.cell_col];
                end
            end
            CMD_CLEAR: begin
                foreach (screen[i]) screen[i] = '0;
            end
            default: ;
        endcase
        r.cell_char    = rd.ch;
        r.cell_back    = rd.back;
        r.cell_fore    = rd.fore;
        r.cell_blink   = rd.blink;
        r.cursor_pos   = CURSOR_W'(cursor_lin);
        r.shown_cursor = CURSOR_W'(shown_lin);
        r.scrolled     = moved;
        return r;
    endfunction

    // Everything is sampled at the rising edge, before the block's registers move.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            foreach (screen[i]) screen[i] = '0;
            cursor_lin = 0;
            shown_lin  = 0;
            back_reg   = '0;
            fore_reg   = 4'd15;
            blink_reg  = 1'b0;
            words_seen = 0;
            console_replies.delete();
        end else begin
            // Outgoing word against the oldest prediction.
            if (m_valid && m_ready) begin
                if (console_replies.size() == 0) begin
                    report_mismatch("result word with no input word waiting for it");
                end else begin
                    want = console_replies.pop_front();
                    check_field("cell_char", m_data.cell_char, want.cell_char);
                    check_field("cell_back", m_data.cell_back, want.cell_back);
                    check_field("cell_fore", m_data.cell_fore, want.cell_fore);
                    check_field("cell_blink", m_data.cell_blink, want.cell_blink);
                    check_field("cursor_pos", m_data.cursor_pos, want.cursor_pos);
                    check_field("shown_cursor", m_data.shown_cursor, want.shown_cursor);
                    check_field("scrolled", m_data.scrolled, want.scrolled);
                end
                words_seen++;
            end

            // Attribute register writes.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BACK_COLOR: back_reg  = cfg_wdata[BACK_W-1:0];
                    CFG_FORE_COLOR: fore_reg  = cfg_wdata[FORE_W-1:0];
                    CFG_BLINK:      blink_reg = cfg_wdata[0];
                    default: ;
                endcase
            end

            // Incoming word: predict its result.
            if (s_valid && s_ready) begin
                console_replies.push_back(console_step(s_data));
            end
        end
        outstanding = console_replies.size();
    end

endmodule

// ===== tb/text_console_cell_writer_tb.sv =====
// Testbench top for the text console cell writer: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module text_console_cell_writer_tb;
    import tccw_pkg::*;

    localparam int               RUN_LIMIT       = 1_000_000;
    localparam int               HOLD_OFF_CYCLES = 300;
    localparam int               PHASE_WORDS     = 410;
    localparam int               TAIL_CYCLES     = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int send_idle;
    int recv_idle;
    int hold_phase;

    text_console_cell_writer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    text_console_cell_writer_check watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("text_console_cell_writer: mismatch");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off each time the main flow asks for one.
    initial begin : result_side
        int seen_hold;
        seen_hold = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_phase != seen_hold) begin
                seen_hold = hold_phase;
                m_ready <= 1'b0;
                for (int held = 1; held < HOLD_OFF_CYCLES; held++) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    function automatic in_t pack_word(input logic [CMD_W-1:0] cmd,
                                      input logic [CHAR_W-1:0] ch,
                                      input logic last,
                                      input logic [CELL_ROW_W-1:0] row,
                                      input logic [CELL_COL_W-1:0] col);
        in_t w;
        w.command   = cmd;
        w.char_code = ch;
        w.last_char = last;
        w.cell_row  = row;
        w.cell_col  = col;
        return w;
    endfunction

    // Mostly text with newlines, some reads, rare clears and unused commands.
    function automatic in_t random_word();
        in_t w;
        int  pick;
        int  sub;
        pick        = $urandom_range(0, 999);
        sub         = $urandom_range(0, 99);
        w.char_code = CHAR_W'($urandom_range(1, 255));
        w.last_char = ($urandom_range(0, 3) == 0);
        w.cell_row  = ($urandom_range(0, 9) == 0) ? CELL_ROW_W'($urandom_range(0, 31))
                                                  : CELL_ROW_W'($urandom_range(0, ROWS - 1));
        w.cell_col  = ($urandom_range(0, 9) == 0) ? CELL_COL_W'($urandom_range(0, 127))
                                                  : CELL_COL_W'($urandom_range(0, COLUMNS - 1));
        if (pick < 700) begin
            w.command = CMD_PUT;
            if (sub < 12) begin
                w.char_code = NEWLINE_CODE;
            end else if (sub < 16) begin
                w.char_code = NUL_CODE;
            end
        end else if (pick < 960) begin
            w.command = CMD_READ;
        end else if (pick < 993) begin
            w.command = CMD_UNUSED;
        end else begin
            w.command = CMD_CLEAR;
        end
        return w;
    endfunction

    // Offers one word, after a random gap, and returns at the falling edge after acceptance.
    task automatic send_word(input in_t w);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    // Writes the three attribute registers on consecutive cycles; only called while no input word is in flight.
    task automatic set_attributes(input logic [CFG_DATA_W-1:0] back,
                                  input logic [CFG_DATA_W-1:0] fore,
                                  input logic [CFG_DATA_W-1:0] flash);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BACK_COLOR;
        cfg_wdata <= back;
        @(negedge aclk);
        cfg_index <= CFG_FORE_COLOR;
        cfg_wdata <= fore;
        @(negedge aclk);
        cfg_index <= CFG_BLINK;
        cfg_wdata <= flash;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit with_hold);
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 2) begin
                hold_phase++;
            end
            send_word(random_word());
        end
    endtask

    // Main flow: reset, directed words, then three random phases with different idling.
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        send_idle  = 24;
        recv_idle  = 57;
        hold_phase = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Highest attributes, with the ignored upper bits set as well.
        set_attributes(4'hF, 4'hF, 4'hF);

        // Reads of a blank screen, including two opposite corners, far out of range and just out of range.
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd0, 7'd0));
        send_word(pack_word(CMD_READ, 8'hFF, 1'b1, 5'd31, 7'd127));
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd24, 7'd79));
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd25, 7'd0));
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd0, 7'd80));
        // Puts: extreme codes, a NUL that still moves the shown cursor, a newline.
        send_word(pack_word(CMD_PUT, 8'hFF, 1'b0, 5'd31, 7'd127));
        send_word(pack_word(CMD_PUT, 8'h01, 1'b1, 5'd0, 7'd0));
        send_word(pack_word(CMD_PUT, NUL_CODE, 1'b1, 5'd0, 7'd0));
        send_word(pack_word(CMD_PUT, 8'h80, 1'b0, 5'd0, 7'd0));
        send_word(pack_word(CMD_PUT, NEWLINE_CODE, 1'b1, 5'd0, 7'd0));
        send_word(pack_word(CMD_PUT, 8'h7F, 1'b0, 5'd0, 7'd0));
        // Read back what was written.
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd0, 7'd0));
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd0, 7'd1));
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd0, 7'd2));
        send_word(pack_word(CMD_READ, 8'h00, 1'b1, 5'd1, 7'd0));
        // Unused command and clear; the last-char flag has no effect on either.
        send_word(pack_word(CMD_UNUSED, 8'h41, 1'b1, 5'd0, 7'd0));
        send_word(pack_word(CMD_CLEAR, 8'h41, 1'b1, 5'd0, 7'd0));
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd0, 7'd0));
        send_word(pack_word(CMD_PUT, 8'h41, 1'b0, 5'd0, 7'd0));
        send_word(pack_word(CMD_READ, 8'h00, 1'b0, 5'd1, 7'd1));
        drain();

        // Sender idles less than the receiver; a long result stall in the middle.
        set_attributes(4'h0, 4'h0, 4'h0);
        run_random(PHASE_WORDS, 1'b1);
        drain();

        // Receiver idles less than the sender; a full pause and new attributes halfway.
        send_idle = 57;
        recv_idle = 24;
        set_attributes(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)),
                       CFG_DATA_W'($urandom_range(0, 15)));
        run_random(PHASE_WORDS / 2, 1'b0);
        drain();
        set_attributes(4'h8, 4'h7, 4'hE);
        run_random(PHASE_WORDS - PHASE_WORDS / 2, 1'b0);
        drain();

        // No idling on either side, back at the reset attributes, another long stall.
        send_idle = 0;
        recv_idle = 0;
        set_attributes(4'h0, 4'hF, 4'h0);
        run_random(PHASE_WORDS, 1'b1);
        drain();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("text_console_cell_writer: match");
        end else begin
            $display("text_console_cell_writer: mismatch");
        end
        $finish;
    end

endmodule

// ===== text_console_cell_writer.f =====
+incdir+hw/rtl
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_datapath.sv
hw/rtl/tccw_ctrl.sv
hw/rtl/text_console_cell_writer.sv
tb/text_console_cell_writer_check.sv
tb/text_console_cell_writer_tb.sv
